### rtl/tacpu_pkg.sv
package tacpu_pkg;

    // flag bit positions
    localparam int unsigned FLAG_Z_BIT = 0;
    localparam int unsigned FLAG_C_BIT = 1;

    // store address that is routed to the debug beat
    localparam logic [31:0] DEBUG_ADDR = 32'h0000_0020;

    // memory operation kinds decoded when an instruction is accepted
    localparam logic [1:0] MOP_NONE  = 2'd0;
    localparam logic [1:0] MOP_LOAD  = 2'd1;
    localparam logic [1:0] MOP_STORE = 2'd2;
    localparam logic [1:0] MOP_CDEC  = 2'd3;

    // result payload
    typedef struct packed {
        logic [15:0] next_pc;
        logic        debug_valid;
        logic [7:0]  debug_value;
        logic        fault;
    } t_result;

endpackage

### rtl/tacpu_if.sv
interface tacpu_instr_if;
    logic       valid;
    logic       ready;
    logic [7:0] instr;

    modport source (output valid, output instr, input ready);
    modport sink (input valid, input instr, output ready);
endinterface

interface tacpu_result_if;
    import tacpu_pkg::*;
    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/tacpu_dmem.sv
module tacpu_dmem
    import tacpu_pkg::*;
#(
    parameter int unsigned MEM_DEPTH = 4096,
    localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data
);

    logic [7:0] r_mem [MEM_DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### rtl/tiny_accumulator_cpu_execute_top.sv
// tiny accumulator cpu execute stage
// input channel: one instruction byte per beat, fetched at the current pc
// output channel: one result beat per instruction (next pc, debug store, fault)
// an instruction is decoded and issues its data memory read when accepted,
// then does the read-modify-write and result in execute on the registered
// read data; no new instruction is accepted until execute has handed the
// last one to the result register. the result register parts the channels:
// a new instruction is accepted while the previous result still waits to be
// taken. after reset the data memory is swept clear, one entry per cycle, over
// all MEM_DEPTH entries; no instruction is accepted during the sweep.
// pc, accumulator, flags and the sixteen registers reset to zero.
// a store to address 0x20 leaves memory alone and raises debug_valid with the
// accumulator value; undefined opcodes raise fault and only advance the pc.
// if the receiver stalls, the result holds and a finished second instruction
// waits in execute until the result register frees.
module tiny_accumulator_cpu_execute_top
    import tacpu_pkg::*;
#(
    parameter int unsigned MEM_DEPTH = 4096,
    parameter int unsigned PC_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tacpu_instr_if.sink           i_instr,
    tacpu_result_if.source        o_result
);

    localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int unsigned CW = AW + 1;

    // architectural state
    logic [PC_BITS-1:0] r_pc;
    logic [7:0]         r_acc;
    logic [1:0]         r_flags;
    logic [7:0]         r_regs [16];

    // clearing sweep
    logic [CW-1:0]      r_clr_cnt;
    logic               r_clr_busy;

    // execute stage registers
    logic               r_ex_valid;
    logic [7:0]         r_ex_op;
    logic [1:0]         r_ex_mop;
    logic [35:0]        r_ex_addr;

    // result register
    logic               r_out_valid;
    t_result            r_out;

    logic               w_can_out;
    logic               w_accept;
    logic               w_ex_fire;
    logic [35:0]        w_addr;
    logic [1:0]         w_mop;
    logic [7:0]         w_rd_data;
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    logic [7:0]         w_mem_wdata;

    // execute result
    logic [PC_BITS-1:0] n_pc;
    logic [7:0]         n_acc;
    logic [1:0]         n_flags;
    logic               n_reg_we;
    logic [7:0]         n_reg_val;
    t_result            n_out;
    logic               n_st_we;
    logic [AW-1:0]      n_st_addr;

    assign w_can_out = !r_out_valid || o_result.ready;
    assign w_ex_fire = r_ex_valid && w_can_out;
    // accept while the sweep is done and execute is empty; the accepted instruction then sits in execute
    assign i_instr.ready = !r_clr_busy && !r_ex_valid;
    assign w_accept  = i_instr.valid && i_instr.ready;

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    // nibble-overlapped address from register groups
    always_comb begin
        logic [3:0] base;
        logic [3:0] cnt;
        logic [7:0] op;
        op     = i_instr.instr;
        w_addr = '0;
        w_mop  = MOP_NONE;
        base   = 4'd0;
        cnt    = 4'd0;
        if (op[7:4] == 4'h2) begin
            base = {op[3:1], 1'b0};
            cnt  = 4'd2;
            w_mop = op[0] ? MOP_STORE : MOP_LOAD;
        end else if ((op & 8'hF2) == 8'h30) begin
            base = {op[3:2], 2'b00};
            cnt  = 4'd4;
            w_mop = op[0] ? MOP_STORE : MOP_LOAD;
        end else if ((op & 8'hF6) == 8'h32) begin
            base = {op[3], 3'b000};
            cnt  = 4'd8;
            w_mop = op[0] ? MOP_STORE : MOP_LOAD;
        end else if ((op & 8'hF7) == 8'h36) begin
            base = {op[3], 3'b000};
            cnt  = 4'd8;
            w_mop = MOP_CDEC;
        end
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < cnt) begin
                w_addr = w_addr | (36'(r_regs[4'(base + 4'(i))]) << (4 * i));
            end
        end
    end

    // execute: works on the registered memory read data
    always_comb begin
        logic [7:0] x;
        logic       c;
        logic       z;
        logic [7:0] r;
        logic [8:0] sum;
        logic       cf;
        logic       is_set;
        logic [3:0] k;
        logic [7:0] op;
        op        = r_ex_op;
        x         = r_acc;
        c         = r_flags[FLAG_C_BIT];
        z         = r_flags[FLAG_Z_BIT];
        r         = r_regs[op[3:0]];
        sum       = '0;
        cf        = op[4];
        is_set    = 1'b0;
        k         = 4'd0;
        n_pc      = r_pc + PC_BITS'(1);
        n_acc     = r_acc;
        n_flags   = r_flags;
        n_reg_we  = 1'b0;
        n_reg_val = r + x;
        n_st_we   = 1'b0;
        n_st_addr = r_ex_addr[AW-1:0];
        n_out     = '0;
        if (op[7:3] == 5'b00000) begin
            is_set = (op[1:0] == 2'd0) ? z : (op[1:0] == 2'd1) ? c : 1'b0;
            if (op[2] ? !is_set : is_set) begin
                n_pc = r_pc + PC_BITS'(2);
            end
        end else if (op == 8'h0E) begin
            n_acc = {4'h0, ~x[3:0]};
        end else if (op == 8'h0F) begin
            n_acc = (x >> 1) | (x & 8'h08);
        end else if (op == 8'h10) begin
            n_acc = x << 1;
        end else if (op == 8'h11) begin
            n_acc = x >> 1;
        end else if (op == 8'h12) begin
            n_acc = {x[6:0], c};
        end else if (op == 8'h13) begin
            n_acc = (x >> 1) | (c ? 8'h08 : 8'h00);
        end else if (r_ex_mop == MOP_LOAD) begin
            n_acc = w_rd_data;
        end else if (r_ex_mop == MOP_STORE) begin
            n_st_we = 1'b1;
        end else if (r_ex_mop == MOP_CDEC) begin
            if (x == w_rd_data) begin
                n_acc   = x - 8'd1;
                n_st_we = 1'b1;
            end
        end else if (op == 8'h37) begin
            n_acc = 8'h00;
        end else if (op[7:4] == 4'h4) begin
            n_acc = r;
        end else if (op[7:4] == 4'h5) begin
            n_reg_we  = 1'b1;
            n_reg_val = x;
        end else if (op[7:4] == 4'h6 || op[7:4] == 4'h7) begin
            n_reg_we  = 1'b1;
            n_reg_val = op[4] ? (r | x) : (r & x);
            n_flags[FLAG_Z_BIT] = (n_reg_val == 8'h00);
        end else if (op[7:6] == 2'b10) begin
            if (!op[5]) begin
                sum = 9'(r) + 9'(x) + 9'(cf && c);
            end else begin
                sum = 9'(r) + 9'(8'(8'h00 - x)) + 9'(cf && !c);
            end
            n_reg_we  = 1'b1;
            n_reg_val = sum[7:0];
            n_flags[FLAG_C_BIT] = sum[7];
            if (!(!z && cf)) begin
                n_flags[FLAG_Z_BIT] = (sum[7:0] == 8'h00);
            end
        end else if (op[7:4] == 4'hD) begin
            n_acc = {4'h0, op[3:0]};
        end else if (op[7:5] == 3'b111) begin
            k = op[3:0];
            if (!op[4]) begin
                n_pc = r_pc + PC_BITS'(1) + PC_BITS'(k);
            end else begin
                n_pc = r_pc + PC_BITS'(1) - PC_BITS'({1'b0, ~k} + 5'd1);
            end
        end else begin
            n_out.fault = 1'b1;
        end
        // the accumulator ops 0x0E-0x13 and loads update z from the new value
        if ((op >= 8'h0E && op <= 8'h13) || r_ex_mop == MOP_LOAD) begin
            n_flags[FLAG_Z_BIT] = (n_acc == 8'h00);
        end
        // debug address diverts the store
        if (n_st_we && r_ex_addr == 36'(DEBUG_ADDR)) begin
            n_st_we           = 1'b0;
            n_out.debug_valid = 1'b1;
            n_out.debug_value = n_acc;
        end
        n_out.next_pc = 16'(32'(n_pc));
    end

    // memory write port shared between sweep and stores
    assign w_mem_we    = r_clr_busy || (w_ex_fire && n_st_we);
    assign w_mem_waddr = r_clr_busy ? r_clr_cnt[AW-1:0] : n_st_addr;
    assign w_mem_wdata = r_clr_busy ? 8'h00 : n_acc;

    tacpu_dmem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dmem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_addr[AW-1:0]),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_mem_we),
        .i_wr_addr (w_mem_waddr),
        .i_wr_data (w_mem_wdata)
    );

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_acc       <= '0;
            r_flags     <= '0;
            r_clr_cnt   <= '0;
            r_clr_busy  <= 1'b1;
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 16; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + CW'(1);
                if (r_clr_cnt == CW'(MEM_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_accept) begin
                r_ex_valid <= 1'b1;
            end else if (w_ex_fire) begin
                r_ex_valid <= 1'b0;
            end
            if (w_ex_fire) begin
                r_pc    <= n_pc;
                r_acc   <= n_acc;
                r_flags <= n_flags;
                if (n_reg_we) begin
                    r_regs[r_ex_op[3:0]] <= n_reg_val;
                end
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ex_op   <= i_instr.instr;
            r_ex_mop  <= w_mop;
            r_ex_addr <= w_addr;
        end
        if (w_ex_fire) begin
            r_out <= n_out;
        end
    end

endmodule
